// ----- hw/rtl/efg_pkg.sv -----
// shared types, codes and constants for the event flag group
`timescale 1ns / 1ps
`default_nettype none

package efg_pkg;

    localparam int WAITERS_DEF = 16;

    localparam int FLAG_W  = 32;
    localparam int TASK_W  = 8;
    localparam int MODE_W  = 3;
    localparam int REQ_W   = 3;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 7;

    // request codes
    localparam logic [REQ_W-1:0] REQ_WAIT         = 3'd0;
    localparam logic [REQ_W-1:0] REQ_TRY_GET      = 3'd1;
    localparam logic [REQ_W-1:0] REQ_NOTIFY_SET   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_NOTIFY_CLEAR = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DESTROY      = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ANSWER   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WOKEN    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASED = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_UNAVAILABLE = 3'd1;
    localparam logic [STAT_W-1:0] ST_QUEUED      = 3'd2;
    localparam logic [STAT_W-1:0] ST_TABLE_FULL  = 3'd3;
    localparam logic [STAT_W-1:0] ST_DELETED     = 3'd4;

    // wait mode bit positions
    localparam int MODE_SET_BIT     = 0;
    localparam int MODE_ALL_BIT     = 1;
    localparam int MODE_CONSUME_BIT = 2;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [MODE_W-1:0] wait_mode;
        logic [FLAG_W-1:0] request_mask;
        logic [TASK_W-1:0] task_id;
    } in_word_t;

    typedef struct packed {
        logic [KIND_W-1:0]  result_kind;
        logic [TASK_W-1:0]  task_id_out;
        logic [STAT_W-1:0]  status;
        logic [FLAG_W-1:0]  matched_flags;
        logic [FLAG_W-1:0]  flag_value;
        logic [COUNT_W-1:0] waiter_count;
        logic               last;
    } out_word_t;

    typedef struct packed {
        logic [TASK_W-1:0] task_id;
        logic [FLAG_W-1:0] mask;
        logic [MODE_W-1:0] mode;
    } waiter_t;

    typedef struct packed {
        logic [FLAG_W-1:0] hit;
        logic              ok;
        logic [FLAG_W-1:0] flags_next;
    } match_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_WALK,
        SEQ_FLUSH
    } seq_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/efg_match.sv -----
// shared flag check and consume unit
`timescale 1ns / 1ps
`default_nettype none

module efg_match
    import efg_pkg::*;
(
    input  wire logic [FLAG_W-1:0] flags,
    input  wire logic [MODE_W-1:0] mode,
    input  wire logic [FLAG_W-1:0] mask,
    output match_t                 result
);

    logic want_set;
    logic need_all;
    logic consume;
    logic [FLAG_W-1:0] hit;
    logic ok;

    always_comb
    begin
        want_set = mode[MODE_SET_BIT];
        need_all = mode[MODE_ALL_BIT];
        consume  = mode[MODE_CONSUME_BIT];
        hit      = want_set ? (flags & mask) : (~flags & mask);
        ok       = need_all ? (hit == mask) : (hit != '0);

        result.hit        = hit;
        result.ok         = ok;
        result.flags_next = flags;
        if (ok && consume)
        begin
            // set match clears the requested bits, clear match sets them
            result.flags_next = want_set ? (flags & ~mask) : (flags | mask);
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/efg_table.sv -----
// waiter table memory, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module efg_table
    import efg_pkg::*;
#(
    parameter int WAITERS = WAITERS_DEF,
    localparam int IDX_W = (WAITERS > 1) ? $clog2(WAITERS) : 1
)
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire waiter_t          wr_data,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output waiter_t               rd_data
);

    waiter_t mem [WAITERS];
    waiter_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/event_flag_group_with_waiters.sv -----
// top level of the event flag group with its ordered waiter table
//
// a 32-bit flag word plus a table of up to WAITERS waiting tasks, oldest
// first. each accepted word produces one answer word and, for a notify or a
// destroy, one wake or release word per affected waiter in table order; the
// final word of a request carries last. wait and try-get are decided, then
// the held answer is flushed. notify and destroy are decided, then walk each
// held waiter, if any, then flush; the output side may stall walk and flush.
// the walk runs one table entry per cycle, unless the output side stalls a
// wake or release word, through a single shared check and consume unit
// while the table memory already reads the next entry; waiters that stay
// are compacted in place through the table's write port. in_ready is low
// for the whole walk. a result is held one stage back so that its last bit
// is known before it goes out, and the output register lets the next result
// be formed while the previous one waits. writing cfg_wr_data while idle
// reloads the flag word and leaves the table alone; reset gives flags zero
// and an empty table, with no clearing pass since the fill count alone
// tells which entries hold waiters.
`timescale 1ns / 1ps
`default_nettype none

module event_flag_group_with_waiters
    import efg_pkg::*;
#(
    parameter int WAITERS = WAITERS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [FLAG_W-1:0] cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_word_t          in_word,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_word_t              out_word
);

    localparam int IDX_W = (WAITERS > 1) ? $clog2(WAITERS) : 1;
    localparam int CNT_W = $clog2(WAITERS + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WAITERS);

    // sequencer and bookkeeping
    seq_state_t        state_reg, state_next;
    logic [FLAG_W-1:0] flag_reg, flag_next;
    logic [CNT_W-1:0]  count_reg, count_next;   // waiters held
    logic [CNT_W-1:0]  idx_reg, idx_next;       // entry under check
    logic [CNT_W-1:0]  keep_reg, keep_next;     // next compacted slot
    logic [CNT_W-1:0]  len_reg, len_next;       // entries to walk
    logic              destroy_reg, destroy_next;

    // held result, not yet known to be last
    logic              pend_valid_reg, pend_valid_next;
    out_word_t         pend_reg, pend_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_reg, out_next;

    // table port and shared unit hookup
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    waiter_t           wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    waiter_t           rd_data;
    logic [MODE_W-1:0] op_mode;
    logic [FLAG_W-1:0] op_mask;
    match_t            m;

    logic              accept;
    logic              out_free;
    logic              advance;
    logic              push;
    logic              last_entry;
    logic [CNT_W-1:0]  idx_inc;
    out_word_t         res;

    efg_match u_match (
        .flags  (flag_reg),
        .mode   (op_mode),
        .mask   (op_mask),
        .result (m)
    );

    efg_table #(
        .WAITERS (WAITERS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // the shared unit sees the request while idle and the table entry in the walk
    assign op_mode = (state_reg == SEQ_IDLE) ? in_word.wait_mode    : rd_data.mode;
    assign op_mask = (state_reg == SEQ_IDLE) ? in_word.request_mask : rd_data.mask;

    assign in_ready  = (state_reg == SEQ_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    assign idx_inc    = idx_reg + 1'b1;
    assign last_entry = (idx_inc == len_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= SEQ_IDLE;
            flag_reg       <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            keep_reg       <= '0;
            len_reg        <= '0;
            destroy_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            flag_reg       <= flag_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            keep_reg       <= keep_next;
            len_reg        <= len_next;
            destroy_reg    <= destroy_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        flag_next       = flag_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        keep_next       = keep_reg;
        len_next        = len_reg;
        destroy_next    = destroy_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        wr_en   = 1'b0;
        wr_addr = keep_reg[IDX_W-1:0];
        wr_data = rd_data;
        rd_en   = 1'b0;
        rd_addr = '0;
        advance = 1'b0;
        push    = 1'b0;
        res     = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    res.result_kind  = KIND_ANSWER;
                    res.status       = ST_OK;
                    res.waiter_count = COUNT_W'(count_reg);
                    state_next       = SEQ_FLUSH;
                    case (in_word.req_type)
                        REQ_WAIT, REQ_TRY_GET:
                        begin
                            res.matched_flags = m.hit;
                            if (m.ok)
                            begin
                                flag_next = m.flags_next;
                            end
                            else if (in_word.req_type == REQ_TRY_GET)
                            begin
                                res.status = ST_UNAVAILABLE;
                            end
                            else if (count_reg == FULL_CNT)
                            begin
                                res.status = ST_TABLE_FULL;
                            end
                            else
                            begin
                                // append behind the youngest waiter
                                res.status       = ST_QUEUED;
                                wr_en            = 1'b1;
                                wr_addr          = count_reg[IDX_W-1:0];
                                wr_data.task_id  = in_word.task_id;
                                wr_data.mask     = in_word.request_mask;
                                wr_data.mode     = in_word.wait_mode;
                                count_next       = count_reg + 1'b1;
                                res.waiter_count = COUNT_W'(count_next);
                            end
                        end
                        REQ_NOTIFY_SET, REQ_NOTIFY_CLEAR, REQ_DESTROY:
                        begin
                            if (in_word.req_type == REQ_NOTIFY_SET)
                            begin
                                flag_next = flag_reg | in_word.request_mask;
                            end
                            else if (in_word.req_type == REQ_NOTIFY_CLEAR)
                            begin
                                flag_next = flag_reg & ~in_word.request_mask;
                            end
                            if (count_reg != '0)
                            begin
                                // start the walk, entry 0 read now
                                rd_en        = 1'b1;
                                rd_addr      = '0;
                                idx_next     = '0;
                                keep_next    = '0;
                                len_next     = count_reg;
                                destroy_next = (in_word.req_type == REQ_DESTROY);
                                state_next   = SEQ_WALK;
                            end
                        end
                        default:
                        begin
                            res.status = ST_UNAVAILABLE;
                        end
                    endcase
                    res.flag_value  = flag_next;
                    pend_valid_next = 1'b1;
                    pend_next       = res;
                end
                if (cfg_wr_en)
                begin
                    flag_next = cfg_wr_data;
                end
            end

            SEQ_WALK:
            begin
                res.task_id_out = rd_data.task_id;
                res.status      = ST_OK;
                if (destroy_reg)
                begin
                    if (out_free)
                    begin
                        res.result_kind = KIND_RELEASED;
                        res.status      = ST_DELETED;
                        res.flag_value  = flag_reg;
                        count_next      = count_reg - 1'b1;
                        push            = 1'b1;
                        advance         = 1'b1;
                    end
                end
                else if (m.ok)
                begin
                    if (out_free)
                    begin
                        flag_next         = m.flags_next;
                        res.result_kind   = KIND_WOKEN;
                        res.matched_flags = m.hit;
                        res.flag_value    = m.flags_next;
                        count_next        = count_reg - 1'b1;
                        push              = 1'b1;
                        advance           = 1'b1;
                    end
                end
                else
                begin
                    // still waiting, slide down to the next free slot
                    wr_en     = 1'b1;
                    wr_addr   = keep_reg[IDX_W-1:0];
                    wr_data   = rd_data;
                    keep_next = keep_reg + 1'b1;
                    advance   = 1'b1;
                end

                res.waiter_count = COUNT_W'(count_next);

                if (push)
                begin
                    // the held result is not last, send it and hold the new one
                    out_valid_next = 1'b1;
                    out_next       = pend_reg;
                    pend_next      = res;
                end

                if (advance)
                begin
                    if (last_entry)
                    begin
                        state_next = SEQ_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                        rd_en    = 1'b1;
                        rd_addr  = idx_inc[IDX_W-1:0];
                    end
                end
            end

            SEQ_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = SEQ_IDLE;
                end
            end

            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// self-checking testbench for the event flag group with its waiter table
`timescale 1ns / 1ps

module testbench;
    import efg_pkg::*;

    localparam int TABLE_DEPTH = WAITERS_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 4;
    localparam int PHASE_ITEMS = 55;

    // request types the block has no name for
    localparam logic [REQ_W-1:0] REQ_BAD_LO  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_BAD_MID = 3'd6;
    localparam logic [REQ_W-1:0] REQ_BAD_HI  = 3'd7;

    // wait mode bits; plain means match clear bits, any bit, keep flags
    localparam logic [MODE_W-1:0] M_PLAIN = 3'b000;
    localparam logic [MODE_W-1:0] M_SET   = 3'b001;
    localparam logic [MODE_W-1:0] M_ALL   = 3'b010;
    localparam logic [MODE_W-1:0] M_TAKE  = 3'b100;

    // one directed probe: the request word and, where obvious, its one answer
    typedef struct packed {
        in_word_t           word;
        logic               typed;
        logic [STAT_W-1:0]  status;
        logic [FLAG_W-1:0]  matched;
        logic [FLAG_W-1:0]  flags;
        logic [COUNT_W-1:0] count;
    } probe_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_wr_en = 1'b0;
    logic [FLAG_W-1:0] cfg_wr_data = '0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_word_t  in_word = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_word;

    // predicted block state
    logic [FLAG_W-1:0] flags_now;
    waiter_t           waiting[$];

    // words the block still owes us, oldest first
    out_word_t awaited[$];
    probe_t    probes[$];

    int          errors = 0;
    int unsigned words_seen = 0;
    int unsigned cycle_count = 0;
    int          fill_left = 0;
    logic        quiet = 1'b0;
    logic        hold_asked = 1'b0;

    event_flag_group_with_waiters uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_word     (in_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_word    (out_word)
    );

    always #10 clk = ~clk;

    // watchdog: a stuck handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at result word %0d: %s", words_seen, what);
        errors++;
    endtask

    function automatic out_word_t pack_result(input logic [KIND_W-1:0] kind,
                                              input logic [TASK_W-1:0] tid,
                                              input logic [STAT_W-1:0] st,
                                              input logic [FLAG_W-1:0] matched,
                                              input logic [FLAG_W-1:0] flags,
                                              input logic [COUNT_W-1:0] cnt);
        out_word_t r;
        r.result_kind   = kind;
        r.task_id_out   = tid;
        r.status        = st;
        r.matched_flags = matched;
        r.flag_value    = flags;
        r.waiter_count  = cnt;
        r.last          = 1'b0;
        return r;
    endfunction

    // test the flags against mask and mode, take the bits on a match
    function automatic logic test_and_take(input logic [MODE_W-1:0] mode,
                                           input logic [FLAG_W-1:0] mask,
                                           output logic [FLAG_W-1:0] hit);
        logic ok;
        hit = mode[MODE_SET_BIT] ? (flags_now & mask) : (~flags_now & mask);
        // need-all with an empty mask matches, need-any with one never does
        ok = mode[MODE_ALL_BIT] ? (hit == mask) : (hit != '0);
        if (ok && mode[MODE_CONSUME_BIT])
            flags_now = mode[MODE_SET_BIT] ? (flags_now & ~mask) : (flags_now | mask);
        return ok;
    endfunction

    // apply one request to the predicted state and queue the words it causes
    function automatic void resolve_request(input in_word_t w);
        out_word_t          batch[$];
        waiter_t            kept[$];
        waiter_t            e;
        logic [FLAG_W-1:0]  hit;
        logic [COUNT_W-1:0] n;
        n = COUNT_W'(waiting.size());
        case (w.req_type)
            REQ_WAIT, REQ_TRY_GET:
            begin
                if (test_and_take(w.wait_mode, w.request_mask, hit))
                    batch.push_back(pack_result(KIND_ANSWER, '0, ST_OK, hit, flags_now, n));
                else if (w.req_type == REQ_TRY_GET)
                    batch.push_back(pack_result(KIND_ANSWER, '0, ST_UNAVAILABLE, hit,
                                                flags_now, n));
                else if (n >= TABLE_DEPTH)
                    batch.push_back(pack_result(KIND_ANSWER, '0, ST_TABLE_FULL, hit,
                                                flags_now, n));
                else
                begin
                    e.task_id = w.task_id;
                    e.mask    = w.request_mask;
                    e.mode    = w.wait_mode;
                    waiting.push_back(e);
                    batch.push_back(pack_result(KIND_ANSWER, '0, ST_QUEUED, hit,
                                                flags_now, n + 1'b1));
                end
            end
            REQ_NOTIFY_SET, REQ_NOTIFY_CLEAR:
            begin
                if (w.req_type == REQ_NOTIFY_SET)
                    flags_now = flags_now | w.request_mask;
                else
                    flags_now = flags_now & ~w.request_mask;
                batch.push_back(pack_result(KIND_ANSWER, '0, ST_OK, '0, flags_now, n));
                // oldest first, each match may eat flags before the next check
                for (int i = 0; i < waiting.size(); i++)
                begin
                    if (test_and_take(waiting[i].mode, waiting[i].mask, hit))
                    begin
                        n--;
                        batch.push_back(pack_result(KIND_WOKEN, waiting[i].task_id, ST_OK,
                                                    hit, flags_now, n));
                    end
                    else
                        kept.push_back(waiting[i]);
                end
                waiting = kept;
            end
            REQ_DESTROY:
            begin
                batch.push_back(pack_result(KIND_ANSWER, '0, ST_OK, '0, flags_now, n));
                for (int i = 0; i < waiting.size(); i++)
                begin
                    n--;
                    batch.push_back(pack_result(KIND_RELEASED, waiting[i].task_id,
                                                ST_DELETED, '0, flags_now, n));
                end
                waiting.delete();
            end
            default:
                batch.push_back(pack_result(KIND_ANSWER, '0, ST_UNAVAILABLE, '0, flags_now, n));
        endcase
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            awaited.push_back(batch[i]);
    endfunction

    task automatic check_result_word(input out_word_t got);
        out_word_t want;
        if (awaited.size() == 0)
        begin
            report_mismatch("word arrived with nothing expected");
            return;
        end
        want = awaited.pop_front();
        if (got.result_kind !== want.result_kind)
            report_mismatch($sformatf("result_kind %0d, expected %0d",
                                      got.result_kind, want.result_kind));
        if (got.task_id_out !== want.task_id_out)
            report_mismatch($sformatf("task_id_out %0h, expected %0h",
                                      got.task_id_out, want.task_id_out));
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.matched_flags !== want.matched_flags)
            report_mismatch($sformatf("matched_flags %h, expected %h",
                                      got.matched_flags, want.matched_flags));
        if (got.flag_value !== want.flag_value)
            report_mismatch($sformatf("flag_value %h, expected %h",
                                      got.flag_value, want.flag_value));
        if (got.waiter_count !== want.waiter_count)
            report_mismatch($sformatf("waiter_count %0d, expected %0d",
                                      got.waiter_count, want.waiter_count));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
    endtask

    function automatic void add_probe(input logic [REQ_W-1:0] req,
                                      input logic [MODE_W-1:0] mode,
                                      input logic [FLAG_W-1:0] mask,
                                      input logic [TASK_W-1:0] tid,
                                      input logic typed,
                                      input logic [STAT_W-1:0] st,
                                      input logic [FLAG_W-1:0] matched,
                                      input logic [FLAG_W-1:0] flags,
                                      input logic [COUNT_W-1:0] cnt);
        probe_t p;
        p.word.req_type     = req;
        p.word.wait_mode    = mode;
        p.word.request_mask = mask;
        p.word.task_id      = tid;
        p.typed             = typed;
        p.status            = st;
        p.matched           = matched;
        p.flags             = flags;
        p.count             = cnt;
        probes.push_back(p);
    endfunction

    // masks biased toward few and low bits so that waits and notifies meet
    function automatic logic [FLAG_W-1:0] pick_mask();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h1 << $urandom_range(0, 31);
            2: return $urandom_range(0, 255);
            3: return '0;
            4: return '1;
            default: return $urandom & $urandom;
        endcase
    endfunction

    function automatic in_word_t next_request();
        in_word_t w;
        int       pick;
        w.task_id      = TASK_W'($urandom_range(0, 255));
        w.wait_mode    = MODE_W'($urandom_range(0, 7));
        w.request_mask = pick_mask();
        if (fill_left > 0)
        begin
            // a wait sure to miss: all bits in the state the flags are not fully in
            fill_left--;
            w.req_type     = REQ_WAIT;
            w.request_mask = '1;
            w.wait_mode    = M_ALL | ((flags_now != '1) ? M_SET : M_PLAIN)
                           | ($urandom_range(0, 1) ? M_TAKE : M_PLAIN);
            return w;
        end
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            // start a run of misses that can overflow the table
            fill_left  = $urandom_range(12, 19);
            w.req_type = REQ_WAIT;
        end
        else if (pick < 45)
            w.req_type = REQ_WAIT;
        else if (pick < 60)
            w.req_type = REQ_TRY_GET;
        else if (pick < 72)
            w.req_type = REQ_NOTIFY_SET;
        else if (pick < 84)
            w.req_type = REQ_NOTIFY_CLEAR;
        else if (pick < 90)
            w.req_type = REQ_DESTROY;
        else if (pick < 95)
            w.req_type = REQ_W'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
        else
            w.req_type = REQ_W'($urandom_range(0, 7));
        return w;
    endfunction

    // offer one word, optionally after a gap, and predict it once taken
    task automatic offer_word(input in_word_t w);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        resolve_request(w);
    endtask

    // drop valid, let every owed word come out, then give the walk time to end
    task automatic settle();
        in_valid <= 1'b0;
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 8) @(posedge clk);
    endtask

    // reloads the flag word only; the waiter table stays
    task automatic load_flags(input logic [FLAG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        flags_now = value;
    endtask

    // result side: checks every taken word and paces out_ready
    initial
    begin : result_side
        int   run_left;
        int   hold_left;
        logic stalled;
        run_left  = 0;
        hold_left = 0;
        stalled   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                check_result_word(out_word);
                words_seen++;
            end
            // long hold-off: the block fills up and must drop in_ready
            if (hold_asked)
            begin
                hold_left  = HOLD_CYCLES;
                hold_asked = 1'b0;
            end
            if (hold_left > 0)
                hold_left--;
            else if (run_left > 0)
                run_left--;
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                stalled  = 1'b1;
                run_left = $urandom_range(0, 13);
            end
            else
            begin
                stalled  = 1'b0;
                run_left = $urandom_range(0, 19);
            end
            out_ready <= quiet || (hold_left == 0 && !stalled);
        end
    end

    // request side
    initial
    begin
        flags_now = '0;

        // after reset: flags zero, table empty
        add_probe(REQ_TRY_GET, M_SET | M_ALL, '1, 8'h00, 1'b1, ST_UNAVAILABLE, '0, '0, 0);
        add_probe(REQ_TRY_GET, M_PLAIN, '1, 8'h00, 1'b1, ST_OK, '1, '0, 0);
        // empty mask: need-all always matches, need-any never does
        add_probe(REQ_TRY_GET, M_SET | M_ALL, '0, 8'h00, 1'b1, ST_OK, '0, '0, 0);
        add_probe(REQ_TRY_GET, M_SET, '0, 8'h00, 1'b1, ST_UNAVAILABLE, '0, '0, 0);
        // unknown request types answer unavailable and change nothing
        add_probe(REQ_BAD_LO, M_PLAIN, '0, 8'h00, 1'b1, ST_UNAVAILABLE, '0, '0, 0);
        add_probe(REQ_BAD_MID, M_SET | M_TAKE, 32'h1234_5678, 8'h42, 1'b1,
                  ST_UNAVAILABLE, '0, '0, 0);
        add_probe(REQ_BAD_HI, M_SET | M_ALL | M_TAKE, '1, 8'hFF, 1'b1,
                  ST_UNAVAILABLE, '0, '0, 0);
        // queue two waiters, one wait that matches at once, one more waiter
        add_probe(REQ_WAIT, M_SET | M_ALL | M_TAKE, 32'h0000_000F, 8'h00, 1'b1,
                  ST_QUEUED, '0, '0, 1);
        add_probe(REQ_WAIT, M_SET, 32'h8000_0000, 8'hFF, 1'b1, ST_QUEUED, '0, '0, 2);
        add_probe(REQ_WAIT, M_ALL | M_TAKE, 32'h0000_00F0, 8'h5A, 1'b1,
                  ST_OK, 32'h0000_00F0, 32'h0000_00F0, 2);
        add_probe(REQ_WAIT, M_PLAIN, 32'h0000_00F0, 8'hA5, 1'b1,
                  ST_QUEUED, '0, 32'h0000_00F0, 3);
        // notifies wake the waiters one by one, with consume on the first
        add_probe(REQ_NOTIFY_SET, M_PLAIN, 32'h0000_000F, 8'h00, 1'b0, ST_OK, '0, '0, 0);
        add_probe(REQ_NOTIFY_CLEAR, M_PLAIN, 32'h0000_00F0, 8'h00, 1'b0, ST_OK, '0, '0, 0);
        add_probe(REQ_NOTIFY_SET, M_PLAIN, '1, 8'h00, 1'b0, ST_OK, '0, '0, 0);
        add_probe(REQ_NOTIFY_CLEAR, M_PLAIN, '0, 8'h00, 1'b0, ST_OK, '0, '0, 0);
        // consume of the whole word both ways
        add_probe(REQ_TRY_GET, M_SET | M_ALL | M_TAKE, '1, 8'h00, 1'b1, ST_OK, '1, '0, 0);
        add_probe(REQ_TRY_GET, M_ALL | M_TAKE, '1, 8'h00, 1'b1, ST_OK, '1, '1, 0);
        // two waiters, then destroy releases both; a second destroy finds none
        add_probe(REQ_WAIT, M_ALL, 32'h0000_0001, 8'h11, 1'b1, ST_QUEUED, '0, '1, 1);
        add_probe(REQ_WAIT, M_TAKE, 32'hFFFF_0000, 8'h22, 1'b1, ST_QUEUED, '0, '1, 2);
        add_probe(REQ_DESTROY, M_PLAIN, '0, 8'h00, 1'b0, ST_OK, '0, '0, 0);
        add_probe(REQ_DESTROY, M_PLAIN, '0, 8'h00, 1'b1, ST_OK, '0, '1, 0);
        // the group stays usable after a destroy
        add_probe(REQ_WAIT, M_SET | M_ALL | M_TAKE, 32'hA5A5_A5A5, 8'h33, 1'b1,
                  ST_OK, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_flags('0);

        // directed probes; typed rows replace the predicted answer
        foreach (probes[i])
        begin
            offer_word(probes[i].word);
            if (probes[i].typed)
            begin
                void'(awaited.pop_back());
                awaited.push_back(pack_result(KIND_ANSWER, '0, probes[i].status,
                                              probes[i].matched, probes[i].flags,
                                              probes[i].count));
                awaited[awaited.size() - 1].last = 1'b1;
            end
        end

        // random phases, each under its own initial flag word
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case (ph)
                0: load_flags('1);
                2: load_flags('0);
                default: load_flags($urandom);
            endcase
            quiet = (ph == PHASES - 1);
            if (ph == 1)
                hold_asked = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
                offer_word(next_request());
        end

        settle();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
